// ===== rtl/crc_pkg.sv =====
// Shared constants and codes for the circle rasterizer.
package crc_pkg;

	// Width of every output coordinate
	localparam int OUT_BITS = 15;

	// Result stream tdata: x_start, x_end, y_pos, padded to whole bytes
	localparam int M_DATA_BITS = ((3 * OUT_BITS + 7) / 8) * 8;

	// Input tuser codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	// Result kind codes
	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_SPAN  = 1'b1;

	// Last result index of a step in each mode
	localparam logic [2:0] LAST_POINT_IDX = 3'd7;
	localparam logic [2:0] LAST_SPAN_IDX  = 3'd3;

endpackage

// ===== rtl/crc_step.sv =====
// One iteration of the three-way decision update of the circle walk.
module crc_step #(
	parameter int RADIUS_BITS = 12
) (
	input  logic signed [RADIUS_BITS:0]   ox,
	input  logic signed [RADIUS_BITS:0]   oy,
	input  logic signed [RADIUS_BITS+2:0] dec,
	input  logic        [RADIUS_BITS-1:0] radius,
	output logic signed [RADIUS_BITS:0]   ox_next,
	output logic signed [RADIUS_BITS:0]   oy_next,
	output logic signed [RADIUS_BITS+2:0] dec_next,
	output logic                          done
);

	localparam int DW = RADIUS_BITS + 3;

	logic signed [DW-1:0] ox_w;
	logic signed [DW-1:0] oy_w;
	logic signed [DW-1:0] rad_w;
	logic signed [DW-1:0] two_ox;
	logic signed [DW-1:0] two_rd;

	always_comb begin
		ox_w   = DW'(ox);
		oy_w   = DW'(oy);
		rad_w  = $signed({{(DW-RADIUS_BITS){1'b0}}, radius});
		two_ox = ox_w <<< 1;
		two_rd = (rad_w - oy_w) <<< 1;

		if (dec >= two_ox) begin
			dec_next = dec - two_ox - DW'(1);
			ox_next  = ox + (RADIUS_BITS+1)'(1);
			oy_next  = oy;
		end else if (dec < two_rd) begin
			dec_next = dec + (oy_w <<< 1) - DW'(1);
			ox_next  = ox;
			oy_next  = oy - (RADIUS_BITS+1)'(1);
		end else begin
			// diagonal move
			dec_next = dec + ((oy_w - ox_w - DW'(1)) <<< 1);
			ox_next  = ox + (RADIUS_BITS+1)'(1);
			oy_next  = oy - (RADIUS_BITS+1)'(1);
		end

		done = oy_next < ox_next;
	end

endmodule

// ===== rtl/circle_rasterizer_core.sv =====
// Circle rasterizer: load a circle, then step it to emit points or spans.
//
// Input channel (s_*): one transfer is either a load (s_tuser = load) that
// stores centre, radius and mode and emits nothing, or a step that runs one
// iteration of the circle walk. A step on a finished or unloaded circle is
// taken and emits nothing.
// Output channel (m_*): a step emits eight points (outline mode) or four
// horizontal spans (fill mode), one transfer per cycle while not stalled by
// m_tready. m_tlast marks the last result of a step; m_tuser[1] is set on
// every result of the step that ends the circle.
// Timing: the walk state is updated in the cycle the step is taken, and the
// step's results are registered as a held copy, from which they are
// sequenced into the output register, so a step occupies the output for
// eight transfers (outline) or four (fill); the next step is taken in the cycle
// its predecessor's last result moves into the output register. Loads and
// idle steps never occupy the output.
// Reset clears the walk (no circle loaded) and empties the output.
// A stall on m_tready holds the output register and, while a held step waits
// behind it, back-pressures s_tready.
module circle_rasterizer_core #(
	parameter int COORD_BITS  = 14,
	parameter int RADIUS_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// center_x, center_y, radius, fill_mode, zero pad
	input  logic [((2*COORD_BITS+RADIUS_BITS+1+7)/8)*8-1:0] s_tdata,
	// action
	input  logic                                        s_tuser,

	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// x_start, x_end, y_pos, zero pad
	output logic [crc_pkg::M_DATA_BITS-1:0]             m_tdata,
	// kind, circle_done
	output logic [1:0]                                  m_tuser,
	// last_of_step
	output logic                                        m_tlast
);

	localparam int C   = COORD_BITS;
	localparam int R   = RADIUS_BITS;
	localparam int DW  = R + 3;
	localparam int OB  = crc_pkg::OUT_BITS;
	localparam int SW  = ((C > R + 1) ? C : R + 1) + 1;
	localparam int MDB = crc_pkg::M_DATA_BITS;

	// Unpacked input fields
	logic signed [C-1:0] in_cx;
	logic signed [C-1:0] in_cy;
	logic        [R-1:0] in_rad;
	logic                in_fill;

	assign in_cx   = $signed(s_tdata[C-1:0]);
	assign in_cy   = $signed(s_tdata[2*C-1:C]);
	assign in_rad  = s_tdata[2*C+R-1:2*C];
	assign in_fill = s_tdata[2*C+R];

	// Walk state
	logic signed [C-1:0]  cx_q;
	logic signed [C-1:0]  cy_q;
	logic        [R-1:0]  rad_q;
	logic                 fill_q;
	logic signed [R:0]    ox_q;
	logic signed [R:0]    oy_q;
	logic signed [DW-1:0] dec_q;
	logic                 active_q;

	logic signed [R:0]    ox_next;
	logic signed [R:0]    oy_next;
	logic signed [DW-1:0] dec_next;
	logic                 step_done;

	crc_step #(
		.RADIUS_BITS(R)
	) u_step (
		.ox      (ox_q),
		.oy      (oy_q),
		.dec     (dec_q),
		.radius  (rad_q),
		.ox_next (ox_next),
		.oy_next (oy_next),
		.dec_next(dec_next),
		.done    (step_done)
	);

	// Mirrored coordinates of the current iteration
	logic signed [OB-1:0] cx_p_ox, cx_m_ox, cx_p_oy, cx_m_oy;
	logic signed [OB-1:0] cy_p_ox, cy_m_ox, cy_p_oy, cy_m_oy;

	always_comb begin
		cx_p_ox = OB'(SW'(cx_q) + SW'(ox_q));
		cx_m_ox = OB'(SW'(cx_q) - SW'(ox_q));
		cx_p_oy = OB'(SW'(cx_q) + SW'(oy_q));
		cx_m_oy = OB'(SW'(cx_q) - SW'(oy_q));
		cy_p_ox = OB'(SW'(cy_q) + SW'(ox_q));
		cy_m_ox = OB'(SW'(cy_q) - SW'(ox_q));
		cy_p_oy = OB'(SW'(cy_q) + SW'(oy_q));
		cy_m_oy = OB'(SW'(cy_q) - SW'(oy_q));
	end

	// Held step being sequenced onto the output
	logic                 job_valid_s1;
	logic                 job_fill_s1;
	logic                 job_done_s1;
	logic signed [OB-1:0] a_s1, b_s1, c_s1, d_s1, e_s1, f_s1, g_s1, h_s1;
	logic        [2:0]    idx_q;

	logic       in_xfer;
	logic       step_emits;
	logic       out_adv;
	logic [2:0] last_idx;
	logic       job_end;

	assign last_idx   = job_fill_s1 ? crc_pkg::LAST_SPAN_IDX : crc_pkg::LAST_POINT_IDX;
	assign out_adv    = job_valid_s1 && (!m_tvalid || m_tready);
	assign job_end    = out_adv && (idx_q == last_idx);
	assign s_tready   = !job_valid_s1 || job_end;
	assign in_xfer    = s_tvalid && s_tready;
	assign step_emits = in_xfer && (s_tuser == crc_pkg::ACT_STEP) && active_q;

	// Result selected by the sequence index
	logic                 sel_kind;
	logic signed [OB-1:0] sel_xs, sel_xe, sel_y;

	always_comb begin
		sel_kind = job_fill_s1 ? crc_pkg::KIND_SPAN : crc_pkg::KIND_POINT;
		sel_xs   = a_s1;
		sel_xe   = a_s1;
		sel_y    = g_s1;
		if (job_fill_s1) begin
			case (idx_q[1:0])
				2'd0: begin sel_xs = d_s1; sel_xe = c_s1; sel_y = e_s1; end
				2'd1: begin sel_xs = b_s1; sel_xe = a_s1; sel_y = g_s1; end
				2'd2: begin sel_xs = b_s1; sel_xe = a_s1; sel_y = h_s1; end
				default: begin sel_xs = d_s1; sel_xe = c_s1; sel_y = f_s1; end
			endcase
		end else begin
			case (idx_q)
				3'd0: begin sel_xs = a_s1; sel_y = g_s1; end
				3'd1: begin sel_xs = c_s1; sel_y = e_s1; end
				3'd2: begin sel_xs = b_s1; sel_y = g_s1; end
				3'd3: begin sel_xs = d_s1; sel_y = e_s1; end
				3'd4: begin sel_xs = a_s1; sel_y = h_s1; end
				3'd5: begin sel_xs = c_s1; sel_y = f_s1; end
				3'd6: begin sel_xs = b_s1; sel_y = h_s1; end
				default: begin sel_xs = d_s1; sel_y = f_s1; end
			endcase
			sel_xe = sel_xs;
		end
	end

	// Walk state control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			rad_q    <= '0;
			fill_q   <= 1'b0;
			ox_q     <= '0;
			oy_q     <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
		end else if (in_xfer) begin
			if (s_tuser == crc_pkg::ACT_LOAD) begin
				cx_q     <= in_cx;
				cy_q     <= in_cy;
				rad_q    <= in_rad;
				fill_q   <= in_fill;
				ox_q     <= '0;
				oy_q     <= $signed({1'b0, in_rad});
				dec_q    <= $signed({{(DW-R){1'b0}}, in_rad}) - DW'(1);
				active_q <= 1'b1;
			end else if (active_q) begin
				ox_q     <= ox_next;
				oy_q     <= oy_next;
				dec_q    <= dec_next;
				active_q <= !step_done;
			end
		end
	end

	// Held step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			idx_q        <= '0;
		end else if (step_emits) begin
			job_valid_s1 <= 1'b1;
			idx_q        <= '0;
		end else if (job_end) begin
			job_valid_s1 <= 1'b0;
			idx_q        <= '0;
		end else if (out_adv) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_emits) begin
			job_fill_s1 <= fill_q;
			job_done_s1 <= step_done;
			a_s1        <= cx_p_ox;
			b_s1        <= cx_m_ox;
			c_s1        <= cx_p_oy;
			d_s1        <= cx_m_oy;
			e_s1        <= cy_p_ox;
			f_s1        <= cy_m_ox;
			g_s1        <= cy_p_oy;
			h_s1        <= cy_m_oy;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			m_tdata <= MDB'({sel_y, sel_xe, sel_xs});
			m_tuser <= {job_done_s1, sel_kind};
			m_tlast <= (idx_q == last_idx);
		end
	end

`ifndef ASSERT_OFF
	// A live walk never has offset y below offset x
	assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (oy_q >= ox_q))
		else $error("walk live with offset y below offset x");

	// A step on a live circle always produces a held step
	assert property (@(posedge clk) disable iff (!arst_n)
		step_emits |=> job_valid_s1 && (idx_q == 3'd0))
		else $error("step taken but no results queued");

	// The final index of a held step is marked as the last transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		job_end |=> m_tvalid && m_tlast)
		else $error("end of step not flagged on output");

	// Fill mode never sequences beyond its four spans
	assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid_s1 && job_fill_s1) |-> !idx_q[2])
		else $error("span index out of range");
`endif

endmodule
